// ===== hw/rtl/deq_pkg.sv =====
// Shared types and constants of the double-ended queue.
package deq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned POS_W    = 5;

  // Front and back read as all ones when the queue holds nothing
  localparam logic signed [DATA_W-1:0] EMPTY_VALUE = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK       = 3'd4,
    CMD_SEARCH     = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

endpackage

// ===== hw/rtl/double_ended_queue_core.sv =====
// Top level of the double-ended queue: command sequencer around the slot store.
//
// A command (command_i, value_i) is taken at a rising edge with start_i high and
// busy_o low. Results appear on the result ports for one cycle each, marked by
// valid_o; the receiver cannot hold them off, so every cycle with valid_o high
// ends in a transfer.
// Push, pop, peek and clear: one result in the cycle after the transfer. The
// slot store is written and both ends are read at the same edge, with write data
// forwarded where the addresses meet. busy_o stays low for these, so a new
// command may follow every cycle: one command per cycle.
// Search: the store is walked from the front, one slot per cycle through read
// port A; busy_o stays high through the walk (ST_SRCH) and the final step
// (ST_SFIN), only ST_SFIN if empty. Each match is held back one step so that the
// final result can carry last_o; without a match one not-found result is given.
// A held match goes out in the cycle after the next match is read; the final
// result comes in the first cycle with busy_o low again.
// Reset clears the front pointer and the count; slot contents are never
// cleared, as only slots written by a push are read.
module double_ended_queue_core #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [deq_pkg::CMD_W-1:0]             command_i,
  input  logic signed [deq_pkg::DATA_W-1:0]     value_i,
  output logic                                  valid_o,
  output logic [deq_pkg::STATUS_W-1:0]          status_o,
  output logic signed [deq_pkg::DATA_W-1:0]     front_value_o,
  output logic signed [deq_pkg::DATA_W-1:0]     back_value_o,
  output logic [deq_pkg::COUNT_W-1:0]           entry_count_o,
  output logic [deq_pkg::POS_W-1:0]             match_position_o,
  output logic                                  last_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESP,
    ST_SRCH,
    ST_SFIN
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0] fp_q, fp_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic                              fwd_a_q, fwd_a_d;
  logic                              fwd_b_q, fwd_b_d;
  logic signed [deq_pkg::DATA_W-1:0] wdata_q, wdata_d;
  deq_pkg::status_e                  rsp_status_q, rsp_status_d;

  logic signed [deq_pkg::DATA_W-1:0] val_q, val_d;
  logic signed [deq_pkg::DATA_W-1:0] fv_q, fv_d;
  logic signed [deq_pkg::DATA_W-1:0] bv_q, bv_d;
  logic [AW-1:0]                     idx_q, idx_d;
  logic [AW-1:0]                     sptr_q, sptr_d;
  logic                              pend_q, pend_d;
  logic [AW-1:0]                     pend_pos_q, pend_pos_d;

  logic                              so_valid_q, so_valid_d;
  deq_pkg::status_e                  so_status_q, so_status_d;
  logic [AW-1:0]                     so_pos_q, so_pos_d;
  logic                              so_last_q, so_last_d;

  logic                              accept;
  logic                              full, empty;
  logic                              ram_we;
  logic [AW-1:0]                     ram_waddr, raddr_a, raddr_b;
  logic signed [deq_pkg::DATA_W-1:0] rdata_a, rdata_b;
  logic [AW-1:0]                     nfp;
  logic [CW-1:0]                     ncnt;
  deq_pkg::status_e                  st;

  function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
    return (p == AW'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] dec_ptr(input logic [AW-1:0] p);
    return (p == '0) ? AW'(CAPACITY - 1) : p - 1'b1;
  endfunction

  // Ring address of p plus off, both below the capacity
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, p} + {1'b0, off};
    if (sum >= (AW+1)'(CAPACITY)) begin
      sum = sum - (AW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  assign busy_o = (state_q == ST_SRCH) || (state_q == ST_SFIN);
  assign accept = start_i && !busy_o;
  assign full   = (cnt_q == CW'(CAPACITY));
  assign empty  = (cnt_q == '0);

  always_comb begin
    state_d      = state_q;
    fp_d         = fp_q;
    cnt_d        = cnt_q;
    fwd_a_d      = fwd_a_q;
    fwd_b_d      = fwd_b_q;
    wdata_d      = wdata_q;
    rsp_status_d = rsp_status_q;
    val_d        = val_q;
    fv_d         = fv_q;
    bv_d         = bv_q;
    idx_d        = idx_q;
    sptr_d       = sptr_q;
    pend_d       = pend_q;
    pend_pos_d   = pend_pos_q;
    so_valid_d   = 1'b0;
    so_status_d  = so_status_q;
    so_pos_d     = so_pos_q;
    so_last_d    = so_last_q;
    ram_we       = 1'b0;
    ram_waddr    = fp_q;
    nfp          = fp_q;
    ncnt         = cnt_q;
    st           = deq_pkg::STATUS_OK;
    raddr_a      = fp_q;
    raddr_b      = wrap_add(fp_q, AW'(cnt_q - 1'b1));

    case (state_q)
      ST_IDLE, ST_RESP: begin
        if (accept) begin
          case (deq_pkg::cmd_e'(command_i))
            deq_pkg::CMD_PUSH_FRONT: begin
              if (full) begin
                st = deq_pkg::STATUS_FULL;
              end else begin
                nfp       = dec_ptr(fp_q);
                ram_we    = 1'b1;
                ram_waddr = nfp;
                ncnt      = cnt_q + 1'b1;
              end
            end
            deq_pkg::CMD_PUSH_BACK: begin
              if (full) begin
                st = deq_pkg::STATUS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = wrap_add(fp_q, AW'(cnt_q));
                ncnt      = cnt_q + 1'b1;
              end
            end
            deq_pkg::CMD_POP_FRONT: begin
              if (empty) begin
                st = deq_pkg::STATUS_EMPTY;
              end else begin
                nfp  = inc_ptr(fp_q);
                ncnt = cnt_q - 1'b1;
              end
            end
            deq_pkg::CMD_POP_BACK: begin
              if (empty) begin
                st = deq_pkg::STATUS_EMPTY;
              end else begin
                ncnt = cnt_q - 1'b1;
              end
            end
            deq_pkg::CMD_SEARCH: begin
              st = deq_pkg::STATUS_OK;
            end
            deq_pkg::CMD_CLEAR: begin
              nfp  = '0;
              ncnt = '0;
            end
            default: begin
              st = empty ? deq_pkg::STATUS_EMPTY : deq_pkg::STATUS_OK;
            end
          endcase

          raddr_a = nfp;
          raddr_b = wrap_add(nfp, AW'(ncnt - 1'b1));
          fp_d    = nfp;
          cnt_d   = ncnt;

          if (deq_pkg::cmd_e'(command_i) == deq_pkg::CMD_SEARCH) begin
            val_d  = value_i;
            pend_d = 1'b0;
            idx_d  = '0;
            sptr_d = fp_q;
            state_d = empty ? ST_SFIN : ST_SRCH;
          end else begin
            rsp_status_d = st;
            fwd_a_d      = ram_we && (ram_waddr == raddr_a);
            fwd_b_d      = ram_we && (ram_waddr == raddr_b);
            wdata_d      = value_i;
            state_d      = ST_RESP;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_SRCH: begin
        raddr_a = inc_ptr(sptr_q);
        if (idx_q == '0) begin
          fv_d = rdata_a;
          bv_d = rdata_b;
        end
        if (rdata_a == val_q) begin
          // A later match exists, so the held one is not the last
          if (pend_q) begin
            so_valid_d  = 1'b1;
            so_status_d = deq_pkg::STATUS_OK;
            so_pos_d    = pend_pos_q;
            so_last_d   = 1'b0;
          end
          pend_d     = 1'b1;
          pend_pos_d = idx_q;
        end
        if (CW'(idx_q) == cnt_q - 1'b1) begin
          state_d = ST_SFIN;
        end else begin
          idx_d  = idx_q + 1'b1;
          sptr_d = inc_ptr(sptr_q);
        end
      end

      ST_SFIN: begin
        so_valid_d = 1'b1;
        so_last_d  = 1'b1;
        if (pend_q) begin
          so_status_d = deq_pkg::STATUS_OK;
          so_pos_d    = pend_pos_q;
        end else begin
          so_status_d = deq_pkg::STATUS_NOT_FOUND;
          so_pos_d    = '0;
        end
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fp_q         <= '0;
      cnt_q        <= '0;
      fwd_a_q      <= 1'b0;
      fwd_b_q      <= 1'b0;
      wdata_q      <= '0;
      rsp_status_q <= deq_pkg::STATUS_OK;
      val_q        <= '0;
      fv_q         <= '0;
      bv_q         <= '0;
      idx_q        <= '0;
      sptr_q       <= '0;
      pend_q       <= 1'b0;
      pend_pos_q   <= '0;
      so_valid_q   <= 1'b0;
      so_status_q  <= deq_pkg::STATUS_OK;
      so_pos_q     <= '0;
      so_last_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      fp_q         <= fp_d;
      cnt_q        <= cnt_d;
      fwd_a_q      <= fwd_a_d;
      fwd_b_q      <= fwd_b_d;
      wdata_q      <= wdata_d;
      rsp_status_q <= rsp_status_d;
      val_q        <= val_d;
      fv_q         <= fv_d;
      bv_q         <= bv_d;
      idx_q        <= idx_d;
      sptr_q       <= sptr_d;
      pend_q       <= pend_d;
      pend_pos_q   <= pend_pos_d;
      so_valid_q   <= so_valid_d;
      so_status_q  <= so_status_d;
      so_pos_q     <= so_pos_d;
      so_last_q    <= so_last_d;
    end
  end

  deq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (value_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Result mux: single-result commands straight from the store, search from registers
  always_comb begin
    if (state_q == ST_RESP) begin
      valid_o          = 1'b1;
      status_o         = rsp_status_q;
      front_value_o    = empty ? deq_pkg::EMPTY_VALUE : (fwd_a_q ? wdata_q : rdata_a);
      back_value_o     = empty ? deq_pkg::EMPTY_VALUE : (fwd_b_q ? wdata_q : rdata_b);
      match_position_o = '0;
      last_o           = 1'b1;
    end else begin
      valid_o          = so_valid_q;
      status_o         = so_status_q;
      front_value_o    = empty ? deq_pkg::EMPTY_VALUE : fv_q;
      back_value_o     = empty ? deq_pkg::EMPTY_VALUE : bv_q;
      match_position_o = deq_pkg::POS_W'(so_pos_q);
      last_o           = so_last_q;
    end
  end

  assign entry_count_o = deq_pkg::COUNT_W'(cnt_q);

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("stored count above capacity");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i != deq_pkg::CMD_SEARCH) |=> (valid_o && last_o))
    else $error("missing result after command transfer");

  a_search_holds_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> ($stable(cnt_q) && $stable(fp_q)))
    else $error("queue changed during search");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && empty && (command_i == deq_pkg::CMD_POP_FRONT ||
     command_i == deq_pkg::CMD_POP_BACK)) |=> (status_o == deq_pkg::STATUS_EMPTY && empty))
    else $error("pop on empty queue misreported");
`endif

endmodule

// ===== hw/rtl/deq_ram.sv =====
// Slot store: one write port, two registered read ports.
module deq_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [AW-1:0]                       waddr_i,
  input  logic signed [deq_pkg::DATA_W-1:0]   wdata_i,
  input  logic [AW-1:0]                       raddr_a_i,
  input  logic [AW-1:0]                       raddr_b_i,
  output logic signed [deq_pkg::DATA_W-1:0]   rdata_a_o,
  output logic signed [deq_pkg::DATA_W-1:0]   rdata_b_o
);

  logic signed [deq_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Old data on a same-address read; the caller forwards
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule
